// ===== hw/rtl/frd_pkg.sv =====
`timescale 1ns / 1ps

package frd_pkg;

    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_EMPTY      = 2'd1;
    localparam logic [1:0] KIND_SIZE_ERROR = 2'd2;

    localparam logic [1:0]  HDR_KEY     = 2'd0;
    localparam logic [1:0]  HDR_LEN_LO  = 2'd1;
    localparam logic [1:0]  HDR_LEN_HI  = 2'd2;

    localparam logic [15:0] HEADER_BYTES    = 16'd3;
    localparam logic [15:0] MAX_BODY_RESET  = 16'd8192;

    typedef struct packed {
        logic        in_body;
        logic [1:0]  header_count;
        logic [7:0]  key;
        logic [15:0] length;
        logic [15:0] index;
    } frame_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] body_length;
        logic [7:0]  frame_key;
        logic        last;
    } frame_result_t;

endpackage

// ===== hw/rtl/frd_step.sv =====
`timescale 1ns / 1ps

module frd_step (
    input  frd_pkg::frame_state_t  state,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            max_body_length,
    output frd_pkg::frame_state_t  state_next,
    output logic                   res_valid,
    output frd_pkg::frame_result_t res
);
    import frd_pkg::*;

    logic [15:0] total;
    logic [15:0] body_len;
    logic [16:0] index_inc;
    logic        body_last;
    logic [7:0]  mask;
    logic [7:0]  offset;
    logic [7:0]  descrambled;

    assign total     = {rx_byte, state.length[7:0]};
    assign body_len  = total - HEADER_BYTES;
    assign index_inc = {1'b0, state.index} + 17'd1;
    assign body_last = index_inc >= {1'b0, state.length};

    // Only the low byte of (n - i) matters for the XOR mask.
    assign mask        = state.key ^ (state.length[7:0] - state.index[7:0]);
    assign offset      = state.index[7:0] ^ state.key;
    assign descrambled = (state.key != 8'd0) ? ((rx_byte ^ mask) - offset) : rx_byte;

    always_comb begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;
        res.frame_key = state.key;
        res.last      = 1'b1;

        if (!state.in_body) begin
            case (state.header_count)
                HDR_KEY: begin
                    state_next.key          = rx_byte;
                    state_next.header_count = HDR_LEN_LO;
                end
                HDR_LEN_LO: begin
                    state_next.length       = {8'd0, rx_byte};
                    state_next.header_count = HDR_LEN_HI;
                end
                default: begin
                    state_next.header_count = HDR_KEY;
                    state_next.index        = 16'd0;
                    if (total < HEADER_BYTES) begin
                        state_next.length = 16'd0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_SIZE_ERROR;
                    end else if (body_len == 16'd0) begin
                        state_next.length = 16'd0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_EMPTY;
                    end else if (body_len > max_body_length) begin
                        state_next.length = 16'd0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_SIZE_ERROR;
                    end else begin
                        state_next.length  = body_len;
                        state_next.in_body = 1'b1;
                    end
                end
            endcase
        end else begin
            res_valid       = 1'b1;
            res.kind        = KIND_BYTE;
            res.data_byte   = descrambled;
            res.byte_index  = state.index;
            res.body_length = state.length;
            res.last        = body_last;
            if (body_last) begin
                // return to the header; leave length as is
                state_next.in_body      = 1'b0;
                state_next.header_count = HDR_KEY;
                state_next.index        = 16'd0;
            end else begin
                state_next.index = index_inc[15:0];
            end
        end
    end

endmodule

// ===== hw/rtl/frame_receive_descrambler.sv =====
`timescale 1ns / 1ps

// Framed byte receiver with on-the-fly descrambling.
// Input channel (s_valid / s_ready / s_rx_byte): one received byte per item.
// Each frame is a key byte, a little-endian 16-bit total length (header
// included), then the body. Header bytes produce no result; the last header
// byte may produce an empty-frame or size-error item instead of a body.
// Result channel (m_valid / m_ready / m_*): one item per body byte, plus one
// item per empty or rejected frame. cfg_we / cfg_wdata load the body limit;
// write it only while the block is idle.
// An accepted item passes through the input register, then the result
// register, before it is presented on m_*. Throughput is one item per
// cycle while the receiver does not stall; the decode is combinational.
// Reset clears the frame state, empties both registers and sets the limit
// to 8192. When the receiver stalls, the result holds and the input register
// fills; s_ready drops only when both are occupied.
module frame_receive_descrambler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_byte_index,
    output logic [15:0] m_body_length,
    output logic [7:0]  m_frame_key,
    output logic        m_last
);
    import frd_pkg::*;

    logic [15:0]   max_len_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    frame_state_t  state_reg;
    frame_state_t  state_next;
    logic          out_valid_reg;
    frame_result_t out_reg;
    logic          res_valid;
    frame_result_t res;
    logic          advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    frd_step u_step (
        .state          (state_reg),
        .rx_byte        (in_byte_reg),
        .max_body_length(max_len_reg),
        .state_next     (state_next),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= MAX_BODY_RESET;
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_data_byte   = out_reg.data_byte;
    assign m_byte_index  = out_reg.byte_index;
    assign m_body_length = out_reg.body_length;
    assign m_frame_key   = out_reg.frame_key;
    assign m_last        = out_reg.last;

    a_body_no_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.in_body |-> state_reg.header_count == HDR_KEY)
        else $error("header count nonzero while in body");

    a_index_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.in_body |-> state_reg.index < state_reg.length)
        else $error("body index ran past body length");

    a_event_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_BYTE |-> m_last && m_data_byte == 8'd0
            && m_body_length == 16'd0)
        else $error("event item with body fields set");

    a_byte_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_BYTE |-> m_byte_index < m_body_length)
        else $error("body item index out of range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import frd_pkg::*;

    typedef struct {
        logic [7:0]    rx;
        bit            typed;
        frame_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [15:0] m_byte_index;
    logic [15:0] m_body_length;
    logic [7:0]  m_frame_key;
    logic        m_last;

    // predictor copy of the frame state and the body limit
    logic        rx_in_body = 1'b0;
    logic [1:0]  rx_hdr_stage = HDR_KEY;
    logic [7:0]  rx_key = 8'h00;
    logic [15:0] rx_len = 16'h0000;
    logic [15:0] rx_idx = 16'h0000;
    logic [15:0] body_limit = MAX_BODY_RESET;

    frame_result_t expected_frames[$];
    logic [7:0]    link_bytes[$];
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_request = 1'b0;

    localparam int DIRECTED_ROWS = 26;

    // header extremes, empty and error frames and the key-zero body carry their result in the row
    stim_row_t directed_rows[DIRECTED_ROWS] = '{
        '{8'hFF, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 16'h0000, 16'h0000, 8'hFF, 1'b1}},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_SIZE_ERROR, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1}},
        '{8'h80, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_SIZE_ERROR, 8'h00, 16'h0000, 16'h0000, 8'h80, 1'b1}},
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_SIZE_ERROR, 8'h00, 16'h0000, 16'h0000, 8'h01, 1'b1}},
        '{8'h7E, 1'b0, '0},
        '{8'h04, 1'b0, '0},
        '{8'h20, 1'b1, '{KIND_SIZE_ERROR, 8'h00, 16'h0000, 16'h0000, 8'h7E, 1'b1}},
        '{8'h00, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hAA, 1'b1, '{KIND_BYTE, 8'hAA, 16'h0000, 16'h0002, 8'h00, 1'b0}},
        '{8'h55, 1'b1, '{KIND_BYTE, 8'h55, 16'h0001, 16'h0002, 8'h00, 1'b1}},
        '{8'hA5, 1'b0, '0},
        '{8'h06, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0}
    };

    frame_receive_descrambler uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_body_length(m_body_length),
        .m_frame_key  (m_frame_key),
        .m_last       (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic bit descramble_step(input logic [7:0] b, output frame_result_t r);
        logic [15:0] total;
        logic [7:0]  d;
        logic        is_last;
        r = '0;
        r.frame_key = rx_key;
        r.last = 1'b1;
        if (!rx_in_body) begin
            if (rx_hdr_stage == HDR_KEY) begin
                rx_key = b;
                rx_hdr_stage = HDR_LEN_LO;
                return 1'b0;
            end
            if (rx_hdr_stage == HDR_LEN_LO) begin
                rx_len = {8'h00, b};
                rx_hdr_stage = HDR_LEN_HI;
                return 1'b0;
            end
            total = {b, rx_len[7:0]};
            rx_hdr_stage = HDR_KEY;
            rx_idx = 16'h0000;
            if (total < HEADER_BYTES) begin
                rx_len = 16'h0000;
                r.kind = KIND_SIZE_ERROR;
                return 1'b1;
            end
            rx_len = total - HEADER_BYTES;
            if (rx_len == 16'h0000) begin
                r.kind = KIND_EMPTY;
                return 1'b1;
            end
            if (rx_len > body_limit) begin
                rx_len = 16'h0000;
                r.kind = KIND_SIZE_ERROR;
                return 1'b1;
            end
            rx_in_body = 1'b1;
            return 1'b0;
        end
        is_last = ({1'b0, rx_idx} + 17'd1 >= {1'b0, rx_len});
        d = b;
        if (rx_key != 8'h00) begin
            d = d ^ (rx_key ^ (rx_len[7:0] - rx_idx[7:0]));
            d = d - (rx_idx[7:0] ^ rx_key);
        end
        r.kind = KIND_BYTE;
        r.data_byte = d;
        r.byte_index = rx_idx;
        r.body_length = rx_len;
        r.last = is_last;
        if (is_last) begin
            rx_in_body = 1'b0;
            rx_hdr_stage = HDR_KEY;
            rx_idx = 16'h0000;
        end else begin
            rx_idx = rx_idx + 16'd1;
        end
        return 1'b1;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected item, kind %0h data %0h index %0h", $time,
                     m_kind, m_data_byte, m_byte_index);
            mismatch_count++;
            return;
        end
        want = expected_frames.pop_front();
        compare_field("kind", 16'(want.kind), 16'(m_kind));
        compare_field("data_byte", 16'(want.data_byte), 16'(m_data_byte));
        compare_field("byte_index", want.byte_index, m_byte_index);
        compare_field("body_length", want.body_length, m_body_length);
        compare_field("frame_key", 16'(want.frame_key), 16'(m_frame_key));
        compare_field("last", 16'(want.last), 16'(m_last));
    endtask

    task automatic push_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
        frame_result_t r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (descramble_step(b, r))
            expected_frames.push_back(typed ? want : r);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_frames.size() != 0);
    endtask

    task automatic write_limit(input logic [15:0] value);
        // finish the queued frames so the next header lines up
        while (link_bytes.size() != 0)
            push_byte(link_bytes.pop_front(), 1'b0, '0);
        drain_results();
        // header bytes give no result, so allow the pipeline to settle
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        body_limit = value;
    endtask

    // mostly well-formed frames, some empty, short or oversize
    task automatic queue_frame();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            n = -$urandom_range(1, 3);
        end else if (sel < 12) begin
            n = 0;
        end else if (sel < 20 && body_limit < 16'd65532) begin
            n = $urandom_range(0, 1) ? body_limit + 1 : $urandom_range(body_limit + 1, 65532);
        end else if (body_limit == 16'd0 || body_limit > 16'd64) begin
            n = $urandom_range(1, 40);
        end else begin
            n = $urandom_range(1, body_limit);
        end
        link_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom()));
        link_bytes.push_back(8'(n + 3));
        link_bytes.push_back(8'((n + 3) >> 8));
        // oversize frames stop at the header
        if (n > 0 && n <= body_limit)
            repeat (n) link_bytes.push_back(8'($urandom()));
    endtask

    task automatic random_bytes(input int count);
        repeat (count) begin
            if (link_bytes.size() == 0)
                queue_frame();
            push_byte(link_bytes.pop_front(), 1'b0, '0);
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(negedge aclk);
            if (m_valid && m_ready)
                check_result();
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 24;
        recv_idle_pct = 64;
        for (int k = 0; k < DIRECTED_ROWS; k++)
            push_byte(directed_rows[k].rx, directed_rows[k].typed, directed_rows[k].want);
        random_bytes(300);
        drain_results();
        random_bytes(300);
        write_limit(16'd0);
        random_bytes(250);

        send_idle_pct = 64;
        recv_idle_pct = 24;
        write_limit(16'd65532);
        hold_request = 1'b1;
        random_bytes(400);
        write_limit(16'd17);
        random_bytes(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(16'($urandom_range(1, 65531)));
        random_bytes(300);

        // one frame whose body sits exactly at the limit
        write_limit(16'd5);
        push_byte(8'($urandom_range(1, 255)), 1'b0, '0);
        push_byte(8'h08, 1'b0, '0);
        push_byte(8'h00, 1'b0, '0);
        repeat (5) push_byte(8'($urandom()), 1'b0, '0);

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
